// File: hdl/mfap_pkg.sv
// ----------------------------------------------------------------------------
// mfap_pkg
// Shared constants, payload types and record layouts for the max-flow block.
// ----------------------------------------------------------------------------
package mfap_pkg;

   localparam int MAX_VERTICES = 512;
   localparam int MAX_ARCS     = 4096;
   localparam int CAP_BITS     = 30;

   localparam int VTX_W   = $clog2(MAX_VERTICES);
   localparam int VCNT_W  = VTX_W + 1;
   localparam int TOP_W   = VTX_W + 1;
   localparam int ARC_W   = $clog2(MAX_ARCS);
   localparam int PTR_W   = ARC_W + 1;
   localparam int FLOW_W  = CAP_BITS + 1;
   localparam int BOT_W   = CAP_BITS + 1;
   localparam int RES_W   = CAP_BITS + 2;
   localparam int SUM_W   = 42;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = VCNT_W;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE       = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SINK         = CSR_IDX_W'(2);

   localparam logic [VCNT_W-1:0] VERTEX_COUNT_RESET = VCNT_W'(MAX_VERTICES);
   localparam logic [VTX_W-1:0]  SOURCE_RESET       = VTX_W'(0);
   localparam logic [VTX_W-1:0]  SINK_RESET         = VTX_W'(1);

   // Arc pointer with the top bit set marks the end of a list.
   localparam logic [PTR_W-1:0] NO_ARC       = PTR_W'(MAX_ARCS);
   localparam logic [SUM_W-1:0] FLOW_MAX     = '1;
   localparam logic [BOT_W-1:0] BOTTLE_START = BOT_W'(1) << CAP_BITS;

   typedef struct packed {
      logic [VTX_W-1:0]    from_vertex;
      logic [VTX_W-1:0]    to_vertex;
      logic [CAP_BITS-1:0] edge_capacity;
      logic                last_edge;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] total_flow;
      logic             store_full;
   } rsp_type;

   typedef struct packed {
      logic [VCNT_W-1:0] vertex_count;
      logic [VTX_W-1:0]  source_vertex;
      logic [VTX_W-1:0]  sink_vertex;
   } cfg_type;

   typedef struct packed {
      logic [VTX_W-1:0]    target;
      logic [CAP_BITS-1:0] capacity;
      logic [ARC_W-1:0]    partner;
   } arc_info_type;

   typedef struct packed {
      logic [PTR_W-1:0] arc;
      logic [BOT_W-1:0] bottleneck;
   } frame_type;

endpackage

// File: hdl/mfap_ram.sv
// ----------------------------------------------------------------------------
// mfap_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module mfap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mfap_engine.sv
// ----------------------------------------------------------------------------
// mfap_engine
// Arc store, adjacency lists and the depth-first augmenting-path sequencer.
// ----------------------------------------------------------------------------
module mfap_engine (
   input  logic              clock,
   input  logic              reset,
   input  mfap_pkg::cfg_type cfg,
   input  mfap_pkg::req_type req_data,
   input  logic              req_accept,
   output logic              idle,
   input  logic              res_free,
   output logic              res_push,
   output mfap_pkg::rsp_type res_data
);
   import mfap_pkg::*;

   localparam logic [4:0] ST_CLR   = 5'd0;
   localparam logic [4:0] ST_IDLE  = 5'd1;
   localparam logic [4:0] ST_E0    = 5'd2;
   localparam logic [4:0] ST_E1    = 5'd3;
   localparam logic [4:0] ST_E2    = 5'd4;
   localparam logic [4:0] ST_E3    = 5'd5;
   localparam logic [4:0] ST_START = 5'd6;
   localparam logic [4:0] ST_VCLR  = 5'd7;
   localparam logic [4:0] ST_SRC0  = 5'd8;
   localparam logic [4:0] ST_SRC1  = 5'd9;
   localparam logic [4:0] ST_X0    = 5'd10;
   localparam logic [4:0] ST_X1    = 5'd11;
   localparam logic [4:0] ST_X2    = 5'd12;
   localparam logic [4:0] ST_POP1  = 5'd13;
   localparam logic [4:0] ST_NXT   = 5'd14;
   localparam logic [4:0] ST_A0    = 5'd15;
   localparam logic [4:0] ST_A1    = 5'd16;
   localparam logic [4:0] ST_A2    = 5'd17;
   localparam logic [4:0] ST_A3    = 5'd18;
   localparam logic [4:0] ST_SUM   = 5'd19;
   localparam logic [4:0] ST_EMIT  = 5'd20;

   logic [4:0]        state_ff, state_in;
   req_type           item_ff, item_in;
   logic [PTR_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              ovf_ff, ovf_in;
   logic [VCNT_W-1:0] idx_ff, idx_in;
   logic [PTR_W-1:0]  cur_arc_ff, cur_arc_in;
   logic [BOT_W-1:0]  cur_b_ff, cur_b_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic [VTX_W-1:0]  tgt_ff, tgt_in;
   logic [RES_W-1:0]  res_ff, res_in;
   logic [PTR_W-1:0]  next_ff, next_in;
   logic [ARC_W-1:0]  partner_ff, partner_in;
   logic [BOT_W-1:0]  ret_ff, ret_in;
   logic [ARC_W-1:0]  aug_ff, aug_in;

   // Memory ports.
   logic                             info_we, flow_we, next_we;
   logic [ARC_W-1:0]                 info_wa, flow_wa, next_wa;
   logic [ARC_W-1:0]                 info_ra, flow_ra, next_ra;
   arc_info_type                     info_wd, info_rd;
   logic [$bits(arc_info_type)-1:0]  info_rd_raw;
   logic [FLOW_W-1:0]                flow_wd, flow_rd;
   logic [PTR_W-1:0]                 next_wd, next_rd;
   logic                             first_we, last_we, vis_we, stk_we;
   logic [VTX_W-1:0]                 first_wa, last_wa, vis_wa, stk_wa;
   logic [VTX_W-1:0]                 first_ra, last_ra, vis_ra, stk_ra;
   logic [PTR_W-1:0]                 first_wd, first_rd, last_wd, last_rd;
   logic                             vis_wd, vis_rd;
   frame_type                        stk_wd, stk_rd;
   logic [$bits(frame_type)-1:0]     stk_rd_raw;

   logic [ARC_W-1:0]  f_arc, r_arc;
   logic [VCNT_W-1:0] n_clear;
   logic [TOP_W-1:0]  top_dec;
   logic [BOT_W-1:0]  b_sel;
   logic [SUM_W:0]    sum_wide;
   logic              store_full_now;

   assign f_arc          = cnt_ff[ARC_W-1:0];
   assign r_arc          = f_arc + ARC_W'(1);
   assign store_full_now = cnt_ff > PTR_W'(MAX_ARCS - 2);
   assign n_clear        = (cfg.vertex_count > VCNT_W'(MAX_VERTICES)) ?
                           VCNT_W'(MAX_VERTICES) : cfg.vertex_count;
   assign top_dec        = top_ff - TOP_W'(1);
   assign b_sel          = (res_ff < RES_W'(cur_b_ff)) ? res_ff[BOT_W-1:0] : cur_b_ff;
   assign sum_wide       = {1'b0, sum_ff} + (SUM_W + 1)'(ret_ff);
   assign info_rd        = arc_info_type'(info_rd_raw);
   assign stk_rd         = frame_type'(stk_rd_raw);

   assign idle                = (state_ff == ST_IDLE);
   assign res_data.total_flow = sum_ff;
   assign res_data.store_full = ovf_ff;

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      ovf_in     = ovf_ff;
      idx_in     = idx_ff;
      cur_arc_in = cur_arc_ff;
      cur_b_in   = cur_b_ff;
      top_in     = top_ff;
      tgt_in     = tgt_ff;
      res_in     = res_ff;
      next_in    = next_ff;
      partner_in = partner_ff;
      ret_in     = ret_ff;
      aug_in     = aug_ff;
      res_push   = 1'b0;

      info_we  = 1'b0;  info_wa  = f_arc;  info_wd  = '0;  info_ra = cur_arc_ff[ARC_W-1:0];
      flow_we  = 1'b0;  flow_wa  = f_arc;  flow_wd  = '0;  flow_ra = cur_arc_ff[ARC_W-1:0];
      next_we  = 1'b0;  next_wa  = f_arc;  next_wd  = NO_ARC;
      next_ra  = cur_arc_ff[ARC_W-1:0];
      first_we = 1'b0;  first_wa = idx_ff[VTX_W-1:0];  first_wd = NO_ARC;
      first_ra = info_rd.target;
      last_we  = 1'b0;  last_wa  = idx_ff[VTX_W-1:0];  last_wd  = NO_ARC;
      last_ra  = item_ff.from_vertex;
      vis_we   = 1'b0;  vis_wa   = idx_ff[VTX_W-1:0];  vis_wd   = 1'b0;
      vis_ra   = info_rd.target;
      stk_we   = 1'b0;  stk_wa   = top_ff[VTX_W-1:0];  stk_wd   = '0;
      stk_ra   = top_dec[VTX_W-1:0];

      unique case (state_ff)
         ST_CLR: begin
            vis_we   = 1'b1;
            first_we = 1'b1;
            last_we  = 1'b1;
            idx_in   = idx_ff + VCNT_W'(1);
            if (idx_ff == VCNT_W'(MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               item_in  = req_data;
               state_in = ST_E0;
            end
         end
         ST_E0: begin
            if (store_full_now) begin
               ovf_in   = 1'b1;
               state_in = item_ff.last_edge ? ST_START : ST_IDLE;
            end else begin
               info_we  = 1'b1;
               info_wd  = '{target: item_ff.to_vertex, capacity: item_ff.edge_capacity,
                             partner: r_arc};
               flow_we  = 1'b1;
               next_we  = 1'b1;
               state_in = ST_E1;
            end
         end
         ST_E1: begin
            info_we  = 1'b1;
            info_wa  = r_arc;
            info_wd  = '{target: item_ff.from_vertex, capacity: '0, partner: f_arc};
            flow_we  = 1'b1;
            flow_wa  = r_arc;
            last_we  = 1'b1;
            last_wa  = item_ff.from_vertex;
            last_wd  = {1'b0, f_arc};
            if (last_rd[ARC_W]) begin
               first_we = 1'b1;
               first_wa = item_ff.from_vertex;
               first_wd = {1'b0, f_arc};
            end else begin
               next_we = 1'b1;
               next_wa = last_rd[ARC_W-1:0];
               next_wd = {1'b0, f_arc};
            end
            state_in = ST_E2;
         end
         ST_E2: begin
            // The tail's list is settled, so a self loop sees the new arc here.
            last_ra  = item_ff.to_vertex;
            next_we  = 1'b1;
            next_wa  = r_arc;
            state_in = ST_E3;
         end
         ST_E3: begin
            last_we  = 1'b1;
            last_wa  = item_ff.to_vertex;
            last_wd  = {1'b0, r_arc};
            if (last_rd[ARC_W]) begin
               first_we = 1'b1;
               first_wa = item_ff.to_vertex;
               first_wd = {1'b0, r_arc};
            end else begin
               next_we = 1'b1;
               next_wa = last_rd[ARC_W-1:0];
               next_wd = {1'b0, r_arc};
            end
            cnt_in   = cnt_ff + PTR_W'(2);
            state_in = item_ff.last_edge ? ST_START : ST_IDLE;
         end
         ST_START: begin
            idx_in   = '0;
            state_in = (cfg.source_vertex == cfg.sink_vertex) ? ST_EMIT : ST_VCLR;
         end
         ST_VCLR: begin
            if (idx_ff < n_clear) begin
               vis_we = 1'b1;
               idx_in = idx_ff + VCNT_W'(1);
            end else begin
               state_in = ST_SRC0;
            end
         end
         ST_SRC0: begin
            vis_we   = 1'b1;
            vis_wa   = cfg.source_vertex;
            vis_wd   = 1'b1;
            first_ra = cfg.source_vertex;
            state_in = ST_SRC1;
         end
         ST_SRC1: begin
            cur_arc_in = first_rd;
            cur_b_in   = BOTTLE_START;
            top_in     = '0;
            state_in   = ST_X0;
         end
         ST_X0: begin
            if (cur_arc_ff[ARC_W]) begin
               ret_in = '0;
               if (top_ff == '0) begin
                  state_in = ST_SUM;
               end else begin
                  top_in   = top_dec;
                  state_in = ST_POP1;
               end
            end else begin
               state_in = ST_X1;
            end
         end
         ST_X1: begin
            tgt_in   = info_rd.target;
            res_in   = RES_W'(info_rd.capacity) -
                       {{(RES_W - FLOW_W){flow_rd[FLOW_W-1]}}, flow_rd};
            next_in  = next_rd;
            state_in = ST_X2;
         end
         ST_X2: begin
            state_in = ST_X0;
            if (vis_rd || res_ff == '0) begin
               cur_arc_in = next_ff;
            end else if (tgt_ff == cfg.sink_vertex) begin
               ret_in   = b_sel;
               aug_in   = cur_arc_ff[ARC_W-1:0];
               state_in = ST_A0;
            end else if (top_ff == TOP_W'(MAX_VERTICES)) begin
               cur_arc_in = next_ff;
            end else begin
               stk_we     = 1'b1;
               stk_wd     = '{arc: cur_arc_ff, bottleneck: cur_b_ff};
               top_in     = top_ff + TOP_W'(1);
               vis_we     = 1'b1;
               vis_wa     = tgt_ff;
               vis_wd     = 1'b1;
               cur_arc_in = first_rd;
               cur_b_in   = b_sel;
            end
         end
         ST_POP1: begin
            // Resume the parent frame at the arc after the one that led here.
            cur_b_in = stk_rd.bottleneck;
            next_ra  = stk_rd.arc[ARC_W-1:0];
            state_in = ST_NXT;
         end
         ST_NXT: begin
            cur_arc_in = next_rd;
            state_in   = ST_X0;
         end
         ST_A0: begin
            info_ra  = aug_ff;
            flow_ra  = aug_ff;
            state_in = ST_A1;
         end
         ST_A1: begin
            flow_we    = 1'b1;
            flow_wa    = aug_ff;
            flow_wd    = flow_rd + FLOW_W'(ret_ff);
            flow_ra    = info_rd.partner;
            partner_in = info_rd.partner;
            state_in   = ST_A2;
         end
         ST_A2: begin
            flow_we = 1'b1;
            flow_wa = partner_ff;
            flow_wd = flow_rd - FLOW_W'(ret_ff);
            if (top_ff == '0) begin
               state_in = ST_SUM;
            end else begin
               top_in   = top_dec;
               state_in = ST_A3;
            end
         end
         ST_A3: begin
            aug_in   = stk_rd.arc[ARC_W-1:0];
            state_in = ST_A0;
         end
         ST_SUM: begin
            sum_in = sum_wide[SUM_W] ? FLOW_MAX : sum_wide[SUM_W-1:0];
            idx_in = '0;
            state_in = (ret_ff == '0) ? ST_EMIT : ST_VCLR;
         end
         ST_EMIT: begin
            if (res_free) begin
               res_push = 1'b1;
               cnt_in   = '0;
               sum_in   = '0;
               ovf_in   = 1'b0;
               idx_in   = '0;
               state_in = ST_CLR;
            end
         end
         default: begin
            state_in = ST_CLR;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
      end
      item_ff    <= item_in;
      cur_arc_ff <= cur_arc_in;
      cur_b_ff   <= cur_b_in;
      top_ff     <= top_in;
      tgt_ff     <= tgt_in;
      res_ff     <= res_in;
      next_ff    <= next_in;
      partner_ff <= partner_in;
      ret_ff     <= ret_in;
      aug_ff     <= aug_in;
   end

   mfap_ram #(.WIDTH($bits(arc_info_type)), .DEPTH(MAX_ARCS)) u_info (
      .clock(clock), .wr_en(info_we), .wr_addr(info_wa), .wr_data(info_wd),
      .rd_addr(info_ra), .rd_data(info_rd_raw)
   );

   mfap_ram #(.WIDTH(FLOW_W), .DEPTH(MAX_ARCS)) u_flow (
      .clock(clock), .wr_en(flow_we), .wr_addr(flow_wa), .wr_data(flow_wd),
      .rd_addr(flow_ra), .rd_data(flow_rd)
   );

   mfap_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ARCS)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(next_ra), .rd_data(next_rd)
   );

   mfap_ram #(.WIDTH(PTR_W), .DEPTH(MAX_VERTICES)) u_first (
      .clock(clock), .wr_en(first_we), .wr_addr(first_wa), .wr_data(first_wd),
      .rd_addr(first_ra), .rd_data(first_rd)
   );

   mfap_ram #(.WIDTH(PTR_W), .DEPTH(MAX_VERTICES)) u_last (
      .clock(clock), .wr_en(last_we), .wr_addr(last_wa), .wr_data(last_wd),
      .rd_addr(last_ra), .rd_data(last_rd)
   );

   mfap_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visited (
      .clock(clock), .wr_en(vis_we), .wr_addr(vis_wa), .wr_data(vis_wd),
      .rd_addr(vis_ra), .rd_data(vis_rd)
   );

   mfap_ram #(.WIDTH($bits(frame_type)), .DEPTH(MAX_VERTICES)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd_raw)
   );

endmodule

// File: hdl/max_flow_augmenting_path.sv
// ----------------------------------------------------------------------------
// max_flow_augmenting_path
// Loads directed edges into an arc store and, on the last edge, finds the
// maximum source-to-sink flow by repeated depth-first augmenting searches.
//
//   Port group   Direction  Carries
//   req_*        in         one edge per item (from, to, capacity, last)
//   rsp_*        out        one result per last edge (total flow, store full)
//   csr_*        in         register writes: vertex count, source, sink
//
// An edge is linked into the adjacency lists in states E0 to E3.
// The last edge starts the search: each search clears the visited flags
// of the first vertex_count vertices (at most 512), then examines arcs and
// augments path arcs, bounded by the single read port of each arc memory.
// After reset and after each result a pass over all 512 vertices empties the
// vertex lists, req_ready low; a held result stops loading at the next one.
// ----------------------------------------------------------------------------
module max_flow_augmenting_path (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mfap_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mfap_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mfap_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mfap_pkg::CSR_DATA_W-1:0]   csr_data
);
   import mfap_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    engine_idle, res_free, res_push;
   rsp_type res_data;

   assign csr_ready = 1'b1;
   assign req_ready = engine_idle;
   assign res_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT: cfg_in.vertex_count  = csr_data[VCNT_W-1:0];
            CSR_SOURCE:       cfg_in.source_vertex = csr_data[VTX_W-1:0];
            CSR_SINK:         cfg_in.sink_vertex   = csr_data[VTX_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vertex_count  <= VERTEX_COUNT_RESET;
         cfg_ff.source_vertex <= SOURCE_RESET;
         cfg_ff.sink_vertex   <= SINK_RESET;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mfap_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_data   (req_data),
      .req_accept (req_valid && req_ready),
      .idle       (engine_idle),
      .res_free   (res_free),
      .res_push   (res_push),
      .res_data   (res_data)
   );

endmodule

// File: hdl/mfap_checker.sv
// ----------------------------------------------------------------------------
// mfap_checker
// Port-level checks on the max-flow block, bound to the top level.
// ----------------------------------------------------------------------------
module mfap_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input mfap_pkg::rsp_type                 rsp_data
);

   // A result that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Linking an edge keeps the engine busy, so ready drops after each item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while the previous one is still linking");

   // A new result starts the store clearing pass.
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_ready)
      else $error("input open while stores are being cleared");

   // Reset starts the clearing pass.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input open right after reset");

endmodule

bind max_flow_augmenting_path mfap_checker u_mfap_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for max_flow_augmenting_path: edges are streamed in as
// small flow networks, a software max-flow predictor computes each network's
// result, and every result item is compared with it field by field.
// ----------------------------------------------------------------------------
module tb;
   import mfap_pkg::*;

   localparam int SETTLE_CYCLES = 700;
   localparam int HOLD_CYCLES   = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   max_flow_augmenting_path u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Register shadow copy.
   int unsigned cur_vcount = MAX_VERTICES;
   int unsigned cur_source = 0;
   int unsigned cur_sink   = 1;

   // Predictor state: arc store, adjacency lists and search stack.
   int unsigned arc_head_vtx [MAX_ARCS];
   longint      arc_cap      [MAX_ARCS];
   longint      arc_used     [MAX_ARCS];
   int unsigned arc_mate     [MAX_ARCS];
   int unsigned arc_link     [MAX_ARCS];
   int unsigned list_first   [MAX_VERTICES];
   int unsigned list_last    [MAX_VERTICES];
   bit          seen         [MAX_VERTICES];
   int unsigned path_arc     [MAX_VERTICES+1];
   longint      path_bottle  [MAX_VERTICES+1];
   int unsigned arcs_loaded;
   longint      flow_total;
   bit          dropped_edges;

   req_type     edge_queue[$];
   rsp_type     flow_expect[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_results = 1'b0;
   bit          start_hold = 1'b0;
   int unsigned edges_sent = 0;
   int unsigned results_seen = 0;
   int unsigned full_results = 0;
   int unsigned err_count = 0;

   function automatic void clear_network();
      for (int v = 0; v < MAX_VERTICES; v++) begin
         list_first[v] = MAX_ARCS;
         list_last[v]  = MAX_ARCS;
         seen[v]       = 1'b0;
      end
      arcs_loaded   = 0;
      flow_total    = 0;
      dropped_edges = 1'b0;
   endfunction

   function automatic void link_arc(int unsigned v, int unsigned a);
      arc_link[a] = MAX_ARCS;
      if (list_last[v] == MAX_ARCS)
         list_first[v] = a;
      else
         arc_link[list_last[v]] = a;
      list_last[v] = a;
   endfunction

   // One depth-first search from src to snk; returns the amount pushed.
   function automatic longint push_one_path(int unsigned src, int unsigned snk);
      int unsigned depth;
      int unsigned a;
      int unsigned t;
      longint      pushed;
      longint      resid;
      longint      b;
      bit          unwinding;
      depth = 0;
      pushed = 0;
      unwinding = 1'b0;
      seen[src] = 1'b1;
      path_arc[0] = list_first[src];
      path_bottle[0] = longint'(1) << CAP_BITS;
      while (1) begin
         if (unwinding) begin
            a = path_arc[depth];
            if (pushed != 0 && a < MAX_ARCS) begin
               arc_used[a] += pushed;
               arc_used[arc_mate[a] % MAX_ARCS] -= pushed;
               if (depth == 0) return pushed;
               depth--;
               continue;
            end
            unwinding = 1'b0;
            if (a < MAX_ARCS) path_arc[depth] = arc_link[a];
         end
         a = path_arc[depth];
         if (a >= MAX_ARCS) begin
            pushed = 0;
            if (depth == 0) return 0;
            depth--;
            unwinding = 1'b1;
            continue;
         end
         t = arc_head_vtx[a] % MAX_VERTICES;
         resid = arc_cap[a] - arc_used[a];
         if (seen[t] || resid == 0) begin
            path_arc[depth] = arc_link[a];
            continue;
         end
         b = path_bottle[depth];
         if (resid < b) b = resid;
         if (t == snk) begin
            pushed = b;
            unwinding = 1'b1;
            continue;
         end
         if (depth + 1 > MAX_VERTICES) begin
            path_arc[depth] = arc_link[a];
            continue;
         end
         depth++;
         seen[t] = 1'b1;
         path_arc[depth] = list_first[t];
         path_bottle[depth] = b;
      end
   endfunction

   function automatic longint max_flow_value();
      int unsigned n;
      longint      got;
      longint      sat;
      sat = (longint'(1) << SUM_W) - 1;
      if (cur_source == cur_sink) return 0;
      n = (cur_vcount > MAX_VERTICES) ? MAX_VERTICES : cur_vcount;
      do begin
         for (int v = 0; v < n; v++) seen[v] = 1'b0;
         got = push_one_path(cur_source, cur_sink);
         if (got > sat - flow_total)
            flow_total = sat;
         else
            flow_total += got;
      end while (got > 0);
      return flow_total;
   endfunction

   // Applies one accepted edge; a last edge queues the expected result.
   function automatic void load_edge(req_type e);
      int unsigned f;
      int unsigned r;
      rsp_type     res;
      if (arcs_loaded + 2 > MAX_ARCS) begin
         dropped_edges = 1'b1;
      end else begin
         f = arcs_loaded;
         r = arcs_loaded + 1;
         arc_head_vtx[f] = e.to_vertex;
         arc_cap[f]      = e.edge_capacity;
         arc_used[f]     = 0;
         arc_mate[f]     = r;
         arc_head_vtx[r] = e.from_vertex;
         arc_cap[r]      = 0;
         arc_used[r]     = 0;
         arc_mate[r]     = f;
         link_arc(e.from_vertex, f);
         link_arc(e.to_vertex, r);
         arcs_loaded += 2;
      end
      if (e.last_edge) begin
         res.total_flow = SUM_W'(max_flow_value());
         res.store_full = dropped_edges;
         flow_expect = {flow_expect, res};
         clear_network();
      end
   endfunction

   initial clear_network();

   // Edge driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            load_edge(req_data);
            edges_sent++;
         end
         if (!req_valid || req_ready) begin
            if (edge_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= edge_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_data.store_full) full_results++;
            if (flow_expect.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("ERROR: unexpected result item, flow %0d full %0b",
                           rsp_data.total_flow, rsp_data.store_full);
            end else if (rsp_data != flow_expect[0]) begin
               err_count++;
               if (err_count <= 10)
                  $display("ERROR: result %0d: flow exp %0d got %0d, full exp %0b got %0b",
                           results_seen, flow_expect[0].total_flow, rsp_data.total_flow,
                           flow_expect[0].store_full, rsp_data.store_full);
               void'(flow_expect.pop_front());
            end else begin
               void'(flow_expect.pop_front());
            end
         end
         rsp_ready <= hold_results ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Long receiver hold-off so that the block backs up onto its input.
   initial begin
      wait (start_hold);
      hold_results = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_results = 1'b0;
   end

   initial begin
      #200_000_000;
      $display("max_flow_augmenting_path verification failed");
      $finish;
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_VERTEX_COUNT: cur_vcount = value % (1 << CSR_DATA_W);
         CSR_SOURCE:       cur_source = value % MAX_VERTICES;
         CSR_SINK:         cur_sink   = value % MAX_VERTICES;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (edge_queue.size() != 0 || req_valid || flow_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void queue_edge(int unsigned f, int unsigned t, int unsigned cap,
                                      bit last);
      req_type e;
      e.from_vertex   = VTX_W'(f);
      e.to_vertex     = VTX_W'(t);
      e.edge_capacity = CAP_BITS'(cap);
      e.last_edge     = last;
      edge_queue = {edge_queue, e};
   endfunction

   // A random network around the current source and sink. Wide capacities go
   // only on tiny networks so the number of augmenting searches stays small.
   function automatic int unsigned queue_network();
      int unsigned pool[8];
      int unsigned n_vtx;
      int unsigned n_edges;
      int unsigned cap;
      bit          wide;
      wide = ($urandom_range(99) < 15);
      n_vtx = $urandom_range(2, 6);
      n_edges = wide ? $urandom_range(1, 3) : $urandom_range(1, 10);
      pool[0] = cur_source;
      pool[1] = cur_sink;
      for (int i = 2; i < 8; i++) pool[i] = $urandom_range(0, MAX_VERTICES-1);
      // Now and then a network that ignores the terminals entirely.
      if ($urandom_range(99) < 8) begin
         pool[0] = $urandom_range(0, MAX_VERTICES-1);
         pool[1] = $urandom_range(0, MAX_VERTICES-1);
      end
      for (int i = 0; i < n_edges; i++) begin
         if (wide)
            cap = $urandom_range(0, (1 << CAP_BITS) - 1);
         else
            cap = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
         queue_edge(pool[$urandom_range(0, n_vtx-1)], pool[$urandom_range(0, n_vtx-1)],
                    cap, i == n_edges - 1);
      end
      return n_edges;
   endfunction

   task automatic random_phase(int unsigned vcount, int unsigned src, int unsigned snk,
                               int unsigned idle, int unsigned stall, int unsigned n_items);
      int unsigned queued;
      write_reg(CSR_VERTEX_COUNT, vcount);
      write_reg(CSR_SOURCE, src);
      write_reg(CSR_SINK, snk);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      queued = 0;
      while (queued < n_items) queued += queue_network();
      wait_drained();
   endtask

   initial begin
      int unsigned s;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed networks with the reset register values (source 0, sink 1).
      queue_edge(0, 1, (1 << CAP_BITS) - 1, 1'b1);
      queue_edge(0, 1, 0, 1'b1);
      queue_edge(0, 2, 5, 1'b0);
      queue_edge(2, 1, 3, 1'b0);
      queue_edge(0, 1, 1000000000, 1'b1);
      queue_edge(0, 511, 7, 1'b0);
      queue_edge(511, 1, 9, 1'b0);
      queue_edge(1, 0, 4, 1'b0);
      queue_edge(0, 0, 3, 1'b1);
      queue_edge(0, 2, 3, 1'b0);
      queue_edge(0, 3, 2, 1'b0);
      queue_edge(2, 3, 5, 1'b0);
      queue_edge(2, 1, 2, 1'b0);
      queue_edge(3, 1, 3, 1'b1);
      queue_edge(5, 6, 9, 1'b1);
      wait_drained();

      // Arc store overflow: one edge more than the store holds.
      queue_edge(0, 1, 2, 1'b0);
      for (int i = 1; i < MAX_ARCS / 2; i++) queue_edge(2, 3, 1, 1'b0);
      queue_edge(0, 1, 6, 1'b1);
      queue_edge(0, 1, 1, 1'b1);
      wait_drained();

      random_phase(512, $urandom_range(0, 511), $urandom_range(0, 511), 0, 0, 170);
      random_phase(1, $urandom_range(0, 511), $urandom_range(0, 511), 85, 0, 170);
      random_phase(1023, 511, 0, 0, 85, 170);
      s = $urandom_range(0, 511);
      random_phase($urandom_range(1, 512), s, s, 30, 30, 120);
      start_hold = 1'b1;
      random_phase(512, 0, 511, 0, 0, 170);
      random_phase($urandom_range(0, 1023), $urandom_range(0, 511), $urandom_range(0, 511),
                   30, 30, 170);

      $display("Covered %0d edge items and %0d flow results (%0d with the store full),",
               edges_sent, results_seen, full_results);
      $display("across vertex counts 0 to 1023, equal terminals and long output stalls.");
      if (err_count == 0 && flow_expect.size() == 0) begin
         $display("max_flow_augmenting_path verification clean");
      end else begin
         $display("max_flow_augmenting_path verification failed");
      end
      $finish;
   end

endmodule
